@@ rtl/tlpw_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpw_pkg: shared types for the three-level page walker
// Beat payloads, result kinds and the walk state record.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpw_pkg;

  localparam int unsigned VaW    = 32;
  localparam int unsigned PaW    = 52;
  localparam int unsigned EntryW = 64;
  localparam int unsigned IdxW   = 9;
  localparam int unsigned OffW   = 12;
  localparam int unsigned TopLsb = 30;
  localparam int unsigned MidLsb = 21;
  localparam int unsigned LowLsb = 12;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_FAULT  = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    LVL_TOP  = 2'd0,
    LVL_MID  = 2'd1,
    LVL_LOW  = 2'd2,
    LVL_NONE = 2'd3
  } level_e;

  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_RESPONSE  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [VaW-1:0]    virt_addr;
    logic [EntryW-1:0] entry_word;
  } in_item_t;

  typedef struct packed {
    kind_e          result_kind;
    logic [PaW-1:0] read_addr;
    logic [PaW-1:0] phys_addr;
    logic [1:0]     fault_level;
  } out_item_t;

  typedef struct packed {
    logic           busy;
    logic [1:0]     level;
    logic [VaW-1:0] vaddr;
  } walk_state_t;

endpackage

`default_nettype wire

@@ rtl/tlpw_step.sv @@
// ----------------------------------------------------------------------------
// tlpw_step: one walk step
// Takes one beat against the current walk state; gives the result beat and
// the next walk state.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpw_step (
  input  tlpw_pkg::walk_state_t        state_i,
  input  logic [tlpw_pkg::PaW-1:0]     table_base_i,
  input  tlpw_pkg::in_item_t           item_i,
  output tlpw_pkg::walk_state_t        state_o,
  output tlpw_pkg::out_item_t          result_o
);

  logic [tlpw_pkg::PaW-1:0]  frame_base;
  logic [tlpw_pkg::PaW-1:0]  top_addr;
  logic [tlpw_pkg::IdxW-1:0] mid_idx;
  logic [tlpw_pkg::IdxW-1:0] low_idx;
  logic [tlpw_pkg::OffW-1:0] page_off;

  assign frame_base = {item_i.entry_word[tlpw_pkg::PaW-1:tlpw_pkg::OffW],
                       {tlpw_pkg::OffW{1'b0}}};
  assign top_addr   = table_base_i
                    + {{(tlpw_pkg::PaW-5){1'b0}},
                       item_i.virt_addr[tlpw_pkg::VaW-1:tlpw_pkg::TopLsb], 3'b000};
  assign mid_idx    = state_i.vaddr[tlpw_pkg::MidLsb +: tlpw_pkg::IdxW];
  assign low_idx    = state_i.vaddr[tlpw_pkg::LowLsb +: tlpw_pkg::IdxW];
  assign page_off   = state_i.vaddr[tlpw_pkg::OffW-1:0];

  always_comb begin
    state_o              = state_i;
    result_o.result_kind = tlpw_pkg::KIND_REJECT;
    result_o.read_addr   = '0;
    result_o.phys_addr   = '0;
    result_o.fault_level = '0;

    if (item_i.req_type == tlpw_pkg::REQ_TRANSLATE) begin
      if (!state_i.busy) begin
        state_o.busy         = 1'b1;
        state_o.level        = tlpw_pkg::LVL_TOP;
        state_o.vaddr        = item_i.virt_addr;
        result_o.result_kind = tlpw_pkg::KIND_READ;
        result_o.read_addr   = top_addr;
      end
    end else if (state_i.busy) begin
      if (!item_i.entry_word[0]) begin
        state_o.busy         = 1'b0;
        state_o.level        = tlpw_pkg::LVL_TOP;
        result_o.result_kind = tlpw_pkg::KIND_FAULT;
        result_o.fault_level = state_i.level;
      end else begin
        case (state_i.level)
          tlpw_pkg::LVL_TOP: begin
            state_o.level        = tlpw_pkg::LVL_MID;
            result_o.result_kind = tlpw_pkg::KIND_READ;
            result_o.read_addr   = frame_base
                                 | {{(tlpw_pkg::PaW-tlpw_pkg::IdxW-3){1'b0}}, mid_idx, 3'b000};
          end
          tlpw_pkg::LVL_MID: begin
            state_o.level        = tlpw_pkg::LVL_LOW;
            result_o.result_kind = tlpw_pkg::KIND_READ;
            result_o.read_addr   = frame_base
                                 | {{(tlpw_pkg::PaW-tlpw_pkg::IdxW-3){1'b0}}, low_idx, 3'b000};
          end
          default: begin
            state_o.busy         = 1'b0;
            state_o.level        = tlpw_pkg::LVL_TOP;
            result_o.result_kind = tlpw_pkg::KIND_DONE;
            result_o.phys_addr   = frame_base
                                 | {{(tlpw_pkg::PaW-tlpw_pkg::OffW){1'b0}}, page_off};
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/three_level_page_walker_core.sv @@
// ----------------------------------------------------------------------------
// three_level_page_walker_core: three-level page table walker
// Turns translate requests and entry read responses into read requests,
// translations, page faults or rejects, one result beat per input beat.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------
//  in      | in  | in_valid_i / in_stall_o | in_data_i  (in_item_t)
//  out     | out | out_valid_o / out_stall_i| out_data_o (out_item_t)
//  cfg     | in  | cfg_valid_i / cfg_ready_o| cfg_data_i (table base)
//
//  One beat per cycle sustained while the out side does not stall; each beat
//  passes the input register, the single walk step and the result register.
//  Reset clears the walk state, table base and both valid flags.
//  An out stall holds the result; the input register still takes one beat
//  and then stalls the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_page_walker_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  tlpw_pkg::in_item_t       in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output tlpw_pkg::out_item_t      out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [tlpw_pkg::PaW-1:0] cfg_data_i
);

  logic                     in_valid_q;
  tlpw_pkg::in_item_t       in_item_q;
  logic                     out_valid_q;
  tlpw_pkg::out_item_t      out_item_q;
  tlpw_pkg::walk_state_t    walk_q, walk_d;
  tlpw_pkg::out_item_t      step_result;
  logic [tlpw_pkg::PaW-1:0] table_base_q;
  logic                     advance;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  tlpw_step u_step (
    .state_i      (walk_q),
    .table_base_i (table_base_q),
    .item_i       (in_item_q),
    .state_o      (walk_d),
    .result_o     (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      walk_q       <= '0;
      table_base_q <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        walk_q      <= walk_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        table_base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_data_i;
    end
    if (advance) begin
      out_item_q <= step_result;
    end
  end

`ifndef ASSERT_OFF
  a_idle_level_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !walk_q.busy |-> walk_q.level == tlpw_pkg::LVL_TOP)
    else $error("idle walker holds a nonzero level");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_q.level != tlpw_pkg::LVL_NONE)
    else $error("walk level out of range");

  a_end_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (step_result.result_kind == tlpw_pkg::KIND_DONE ||
                step_result.result_kind == tlpw_pkg::KIND_FAULT) |=> !walk_q.busy)
    else $error("walk still busy after it ended");

  a_start_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !walk_q.busy && step_result.result_kind == tlpw_pkg::KIND_READ
    |=> walk_q.busy)
    else $error("walk did not start on a translate request");
`endif

endmodule

`default_nettype wire

@@ sim/walk_scoreboard_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// walk_scoreboard_pkg: expected-beat tracking for the page walker bench
// Keeps a private copy of the walk state and table base. It turns each input
// beat into the result beat that the walker should give. It then checks the
// result beats in order.
// ----------------------------------------------------------------------------
package walk_scoreboard_pkg;

  import tlpw_pkg::*;

  class walk_scoreboard;
    logic [PaW-1:0] table_base;
    bit             busy;
    level_e         level;
    logic [VaW-1:0] vaddr;
    out_item_t      expected_q[$];
    int unsigned    errors;

    function new();
      table_base = '0;
      busy       = 1'b0;
      level      = LVL_TOP;
      vaddr      = '0;
      errors     = 0;
    endfunction

    function void set_base(logic [PaW-1:0] base);
      table_base = base;
    endfunction

    function void note_beat(in_item_t beat);
      out_item_t      res;
      logic [PaW-1:0] frame;
      logic [PaW-1:0] top_off;
      logic [PaW-1:0] mid_off;
      logic [PaW-1:0] low_off;
      logic [PaW-1:0] page_off;
      res             = '0;
      res.result_kind = KIND_REJECT;
      frame    = {beat.entry_word[PaW-1:OffW], {OffW{1'b0}}};
      top_off  = {{(PaW-5){1'b0}}, beat.virt_addr[VaW-1:TopLsb], 3'b000};
      mid_off  = {{(PaW-IdxW-3){1'b0}}, vaddr[MidLsb +: IdxW], 3'b000};
      low_off  = {{(PaW-IdxW-3){1'b0}}, vaddr[LowLsb +: IdxW], 3'b000};
      page_off = {{(PaW-OffW){1'b0}}, vaddr[OffW-1:0]};
      if (beat.req_type == REQ_TRANSLATE) begin
        if (!busy) begin
          busy            = 1'b1;
          level           = LVL_TOP;
          vaddr           = beat.virt_addr;
          res.result_kind = KIND_READ;
          res.read_addr   = table_base + top_off;
        end
      end else if (busy) begin
        if (!beat.entry_word[0]) begin
          res.result_kind = KIND_FAULT;
          res.fault_level = level;
          busy            = 1'b0;
          level           = LVL_TOP;
        end else begin
          case (level)
            LVL_TOP: begin
              level           = LVL_MID;
              res.result_kind = KIND_READ;
              res.read_addr   = frame + mid_off;
            end
            LVL_MID: begin
              level           = LVL_LOW;
              res.result_kind = KIND_READ;
              res.read_addr   = frame + low_off;
            end
            default: begin
              res.result_kind = KIND_DONE;
              res.phys_addr   = frame + page_off;
              busy            = 1'b0;
              level           = LVL_TOP;
            end
          endcase
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_beat(out_item_t act);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", act);
        return;
      end
      exp = expected_q.pop_front();
      if (act.result_kind !== exp.result_kind || act.read_addr !== exp.read_addr ||
          act.phys_addr !== exp.phys_addr || act.fault_level !== exp.fault_level) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp/act: kind %0d/%0d read %h/%h phys %h/%h level %0d/%0d",
                   exp.result_kind, act.result_kind, exp.read_addr, act.read_addr,
                   exp.phys_addr, act.phys_addr, exp.fault_level, act.fault_level);
      end
    endfunction

    function void close_out();
      if (expected_q.size() != 0) begin
        $display("%0d result beats never arrived", expected_q.size());
        errors += expected_q.size();
      end
    endfunction
  endclass

endpackage

@@ sim/three_level_page_walker_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_level_page_walker_core_tb: bench for the three-level page walker
// A directed set of walks covers the field extremes, rejects, faults at each
// level and the top-address wrap. Random walks follow under several table
// bases, with mostly well-formed sequences plus noise. Both sides idle in
// random bursts.
// ----------------------------------------------------------------------------
module three_level_page_walker_core_tb;

  import tlpw_pkg::*;
  import walk_scoreboard_pkg::*;

  localparam logic [PaW-1:0]    BaseMax  = {PaW{1'b1}};
  localparam logic [EntryW-1:0] EntryAll = {EntryW{1'b1}};

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  in_item_t       in_data_i   = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  out_item_t      out_data_o;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [PaW-1:0] cfg_data_i  = '0;

  walk_scoreboard sb = new();

  int unsigned item_cnt   = 0;
  bit          quiet      = 1'b0;
  int unsigned stall_left = 0;
  int unsigned stall_calm = 0;
  int unsigned in_calm    = 0;

  three_level_page_walker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
      if (stall_calm != 0) begin
        stall_calm--;
      end else if (!quiet) begin
        if ($urandom_range(0, 49) == 0) stall_calm = $urandom_range(30, 80);
        else if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_beat(out_data_o);
  end

  task automatic send_beat(logic req, logic [VaW-1:0] va, logic [EntryW-1:0] entry);
    in_item_t beat;
    beat.req_type   = req;
    beat.virt_addr  = va;
    beat.entry_word = entry;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_beat(beat);
    item_cnt++;
  endtask

  task automatic sender_gap();
    int unsigned n;
    if (in_calm != 0) begin
      in_calm--;
    end else if (!quiet) begin
      if ($urandom_range(0, 39) == 0) begin
        in_calm = $urandom_range(20, 60);
      end else if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        repeat (n) begin
          @(negedge clk_i);
          in_valid_i = 1'b0;
        end
      end
    end
  endtask

  task automatic send_random(logic req, logic [EntryW-1:0] entry);
    send_beat(req, $urandom, entry);
    sender_gap();
  endtask

  // hold input until every expected beat is back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_base(logic [PaW-1:0] base);
    drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = base;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_base(base);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_walk();
    int unsigned      noise;
    int unsigned      noise_lvl;
    logic [VaW-1:0]   va;
    logic [EntryW-1:0] entry;
    bit               ended;
    noise     = $urandom_range(0, 9);
    noise_lvl = $urandom_range(0, 2);
    ended     = 1'b0;
    va        = $urandom;
    case ($urandom_range(0, 15))
      0: va = '0;
      1: va = '1;
      default: ;
    endcase
    if (noise == 0) send_random(REQ_RESPONSE, {$urandom, $urandom});
    send_beat(REQ_TRANSLATE, va, {$urandom, $urandom});
    sender_gap();
    for (int lvl = 0; lvl < 3; lvl++) begin
      if (!ended) begin
        if (noise == 1 && lvl == noise_lvl)
          send_random(REQ_TRANSLATE, {$urandom, $urandom});
        entry    = {$urandom, $urandom};
        entry[0] = ($urandom_range(0, 7) != 0);
        send_random(REQ_RESPONSE, entry);
        ended = !entry[0];
      end
    end
  endtask

  task automatic run_phase(logic [PaW-1:0] base, int unsigned stop_at, bit hold_mid);
    write_base(base);
    while (item_cnt < stop_at) begin
      run_walk();
      if (hold_mid && item_cnt > stop_at - 60 && item_cnt < stop_at - 50) drain();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed
    write_base(BaseMax);
    send_beat(REQ_RESPONSE, '1, EntryAll);             // response while idle
    send_beat(REQ_TRANSLATE, '1, '0);                  // top address wraps
    send_beat(REQ_TRANSLATE, '0, EntryAll);            // request while busy
    send_beat(REQ_RESPONSE, '0, EntryAll);
    send_beat(REQ_RESPONSE, '0, EntryAll);
    send_beat(REQ_RESPONSE, '0, EntryAll);
    send_beat(REQ_TRANSLATE, '0, '0);
    send_beat(REQ_RESPONSE, '1, '0);                   // fault at top
    send_beat(REQ_TRANSLATE, 32'h4000_0000, '0);
    send_beat(REQ_RESPONSE, '0, 64'hFFF0_0000_0000_0001);  // high bits ignored
    send_beat(REQ_RESPONSE, '0, {EntryAll[EntryW-1:1], 1'b0}); // fault at mid
    send_beat(REQ_TRANSLATE, 32'hAAAA_AAAA, EntryAll);
    send_beat(REQ_RESPONSE, 32'h5555_5555, 64'h0000_0000_0000_0001);
    send_beat(REQ_RESPONSE, 32'h5555_5555, 64'h000A_BCDE_F012_3001);
    send_beat(REQ_RESPONSE, '0, {EntryAll[EntryW-1:1], 1'b0}); // fault at low
    send_beat(REQ_RESPONSE, '0, '0);
    write_base('0);
    send_beat(REQ_TRANSLATE, 32'h1234_5678, '0);
    send_beat(REQ_RESPONSE, '1, 64'h0005_5555_5555_5001);
    send_beat(REQ_RESPONSE, '1, 64'h000A_AAAA_AAAA_A001);
    send_beat(REQ_RESPONSE, '1, 64'h5A5A_5A5A_5A5A_5001);

    // random
    run_phase(PaW'({$urandom, $urandom}), 180, 1'b0);
    run_phase('0, 330, 1'b1);
    run_phase(BaseMax, 480, 1'b0);
    quiet = 1'b1;
    run_phase(PaW'({$urandom, $urandom}), 620, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ three_level_page_walker_core.f @@
rtl/tlpw_pkg.sv
rtl/tlpw_step.sv
rtl/three_level_page_walker_core.sv
sim/walk_scoreboard_pkg.sv
sim/three_level_page_walker_core_tb.sv
